/* hdl/assert_macros.svh */
// Assertion helpers; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

/* hdl/ica_pkg.sv */
`default_nettype none
package ica_pkg;
  localparam int DataWidth = 32;
  localparam int OpWidth = 3;
  localparam int StWidth = 3;

  localparam logic [OpWidth-1:0] OpAdd  = 3'd0;
  localparam logic [OpWidth-1:0] OpSub  = 3'd1;
  localparam logic [OpWidth-1:0] OpMul  = 3'd2;
  localparam logic [OpWidth-1:0] OpDiv  = 3'd3;
  localparam logic [OpWidth-1:0] OpSqrt = 3'd4;

  localparam logic [StWidth-1:0] StOk      = 3'd0;
  localparam logic [StWidth-1:0] StBadOp   = 3'd1;
  localparam logic [StWidth-1:0] StDiv0    = 3'd2;
  localparam logic [StWidth-1:0] StNegRoot = 3'd3;
  localparam logic [StWidth-1:0] StDivOvf  = 3'd4;

  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result;
    logic [StWidth-1:0]   status;
  } out_t;
endpackage
`default_nettype wire

/* hdl/ica_stage.sv */
`default_nettype none
// One iteration of the restoring divider and the digit-by-digit root.
// Divider: shift in one dividend bit, subtract divisor if it fits.
// Root: bring down two radicand bits, try (root<<2)|1 against remainder.
module ica_stage #(
  parameter int W = ica_pkg::DataWidth,
  parameter int Idx = 0
) (
  input  wire logic [W-1:0]   dq_in,
  input  wire logic [W-1:0]   drem_in,
  input  wire logic [W-1:0]   dvs,
  input  wire logic [W-1:0]   rad_in,
  input  wire logic [W/2:0]   rroot_in,
  input  wire logic [W/2+2:0] rrem_in,
  output logic [W-1:0]        dq_out,
  output logic [W-1:0]        drem_out,
  output logic [W/2:0]        rroot_out,
  output logic [W/2+2:0]      rrem_out
);
  logic [W:0]     dtrial;
  logic [W:0]     ddiff;
  logic [W/2+2:0] rtrial;
  logic [W/2+2:0] rtest;

  // Restoring divide step on quotient bit W-1-Idx
  assign dtrial = {drem_in, dq_in[W-1]};
  assign ddiff = dtrial - {1'b0, dvs};
  always_comb begin
    if (!ddiff[W]) begin
      drem_out = ddiff[W-1:0];
      dq_out = {dq_in[W-2:0], 1'b1};
    end else begin
      drem_out = dtrial[W-1:0];
      dq_out = {dq_in[W-2:0], 1'b0};
    end
  end

  // Root step on radicand pair Idx (only the first W/2 stages count)
  assign rtrial = {rrem_in[W/2:0], rad_in[W-1-2*(Idx%(W/2)) -: 2]};
  assign rtest = {rroot_in, 2'b01};
  always_comb begin
    if (rtrial >= rtest) begin
      rrem_out = rtrial - rtest;
      rroot_out = {rroot_in[W/2-1:0], 1'b1};
    end else begin
      rrem_out = rtrial;
      rroot_out = {rroot_in[W/2-1:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

/* hdl/integer_calculator_alu_top.sv */
`default_nettype none
// Each request passes the load register, the iteration stages and the final select register before its result is valid.
// Throughput: one request per cycle while the output is not held; one divide/root iteration per stage.
// Multiply forms three half-width partial products, combined over 2 stages.
// Reset: rst (synchronous) clears all stage valid bits; payload is not reset.
`include "assert_macros.svh"
module integer_calculator_alu_top (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire ica_pkg::in_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output ica_pkg::out_t out_data
);
  localparam int W = ica_pkg::DataWidth;
  localparam int H = W / 2;
  localparam int NS = W + 1;

  typedef struct packed {
    logic [ica_pkg::OpWidth-1:0] op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         neg_q;
    logic [W-1:0] dq;
    logic [W-1:0] drem;
    logic [W-1:0] dvs;
    logic [W-1:0] rad;
    logic [H:0]   rroot;
    logic [H+2:0] rrem;
    logic [W-1:0] mlo;
    logic [W-1:0] mhi;
  } pipe_t;

  logic  advance;
  logic  [NS:0] vld;
  pipe_t pipe [NS+1];
  pipe_t nxt [NS+1];
  logic [W-1:0] in_a;
  logic [W-1:0] in_b;

  // Advance the whole pipe unless the output register is held
  assign advance = !vld[NS] || out_ready;
  assign in_ready = advance;
  assign in_a = W'(in_data.operand_a);
  assign in_b = W'(in_data.operand_b);

  // Stage 0 load: magnitudes and root setup
  always_comb begin
    nxt[0] = '0;
    nxt[0].op = in_data.op;
    nxt[0].a = in_a;
    nxt[0].b = in_b;
    nxt[0].neg_q = in_a[W-1] ^ in_b[W-1];
    nxt[0].dq = in_a[W-1] ? W'(-in_a) : in_a;
    nxt[0].dvs = in_b[W-1] ? W'(-in_b) : in_b;
    nxt[0].rad = in_a;
  end

  // Iteration stages
  for (genvar i = 0; i < W; i++) begin : g_it
    logic [W-1:0] dq_o;
    logic [W-1:0] drem_o;
    logic [H:0]   rroot_o;
    logic [H+2:0] rrem_o;
    ica_stage #(.W(W), .Idx(i)) u_stage (
      .dq_in(pipe[i].dq), .drem_in(pipe[i].drem), .dvs(pipe[i].dvs),
      .rad_in(pipe[i].rad), .rroot_in(pipe[i].rroot), .rrem_in(pipe[i].rrem),
      .dq_out(dq_o), .drem_out(drem_o), .rroot_out(rroot_o), .rrem_out(rrem_o)
    );
    always_comb begin
      nxt[i+1] = pipe[i];
      nxt[i+1].dq = dq_o;
      nxt[i+1].drem = drem_o;
      if (i < H) begin
        nxt[i+1].rroot = rroot_o;
        nxt[i+1].rrem = rrem_o;
      end
      // Multiply: partial products in stage 0, sum in stage 1
      if (i == 0) begin
        nxt[1].mlo = W'(pipe[0].a[H-1:0] * pipe[0].b[H-1:0]);
        nxt[1].mhi = W'(pipe[0].a[W-1:H] * pipe[0].b[H-1:0]
                      + pipe[0].a[H-1:0] * pipe[0].b[W-1:H]);
      end
      if (i == 1) begin
        nxt[2].mlo = pipe[1].mlo + (pipe[1].mhi << H);
      end
    end
  end

  // Final stage: select result and status
  always_comb begin
    logic [W-1:0] a;
    logic [W-1:0] b;
    a = pipe[W].a;
    b = pipe[W].b;
    nxt[W+1] = pipe[W];
    nxt[W+1].mhi = '0;
    nxt[W+1].rrem = (H+3)'(ica_pkg::StOk);
    case (pipe[W].op)
      ica_pkg::OpAdd: nxt[W+1].mhi = a + b;
      ica_pkg::OpSub: nxt[W+1].mhi = a - b;
      ica_pkg::OpMul: nxt[W+1].mhi = pipe[W].mlo;
      ica_pkg::OpDiv: begin
        if (b == '0) begin
          nxt[W+1].rrem = (H+3)'(ica_pkg::StDiv0);
        end else if (a == {1'b1, {(W-1){1'b0}}} && b == '1) begin
          nxt[W+1].mhi = a;
          nxt[W+1].rrem = (H+3)'(ica_pkg::StDivOvf);
        end else begin
          nxt[W+1].mhi = pipe[W].neg_q ? W'(-pipe[W].dq) : pipe[W].dq;
        end
      end
      ica_pkg::OpSqrt: begin
        if (a[W-1]) nxt[W+1].rrem = (H+3)'(ica_pkg::StNegRoot);
        else nxt[W+1].mhi = W'(pipe[W].rroot);
      end
      default: nxt[W+1].rrem = (H+3)'(ica_pkg::StBadOp);
    endcase
  end

  // Register every stage and its valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end
  for (genvar s = 0; s <= NS; s++) begin : g_reg
    always_ff @(posedge clk) begin
      if (advance) pipe[s] <= nxt[s];
    end
  end

  assign out_valid = vld[NS];
  assign out_data.result = pipe[NS].mhi;
  assign out_data.status = pipe[NS].rrem[ica_pkg::StWidth-1:0];

  `ASSERT_CLK(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result dropped under stall")
  `ASSERT_CLK(a_rdy, clk, rst, !out_valid |-> in_ready, "pipe stalled while output empty")
  `ASSERT_CLK(a_st, clk, rst, out_valid |-> out_data.status <= ica_pkg::StDivOvf, "status code out of range")
  `ASSERT_CLK_NR(a_rst, clk, $past(rst) |-> !out_valid, "valid after reset")
endmodule
`default_nettype wire
